// ----- rtl/core/subsystem_on_time_accumulator_core_defines.svh -----
// Assertion macros for the on-time accumulator core.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef SUBSYSTEM_ON_TIME_ACCUMULATOR_CORE_DEFINES_SVH
`define SUBSYSTEM_ON_TIME_ACCUMULATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SOTA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SOTA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/sota_pkg.sv -----
`timescale 1ns / 1ps

package sota_pkg;

	// field widths
	localparam int OP_W   = 2;
	localparam int SUB_W  = 6;
	localparam int TS_W   = 64;
	localparam int KIND_W = 3;

	// op codes
	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_OK        = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REPEAT    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IDLE_STOP = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DISABLED  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_REPORT    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd5;

	// what the output register is loaded from
	typedef enum logic [1:0] {
		SEL_SINGLE,
		SEL_HELD,
		SEL_EMPTY
	} out_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic              ready;
		logic              use_idx;
		logic              kind_ld;
		logic [KIND_W-1:0] kind;
		logic              stamp_wr;
		logic              stop_upd;
		logic              flush_upd;
		logic              sum_ld;
		logic              idx_clr;
		logic              idx_inc;
		logic              held_clr;
		logic              held_take;
		logic              out_ld;
		out_sel_t          out_sel;
		logic              out_last;
	} sota_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            en;
		logic            in_range;
		logic            run;
		logic            pend;
		logic            idx_last;
		logic            sum_zero;
		logic            held_v;
		logic            out_free;
	} sota_stat_t;

endpackage

// ----- rtl/core/sota_cmd_if.sv -----
`timescale 1ns / 1ps

interface sota_cmd_if;
	import sota_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  op;
	logic [SUB_W-1:0] subsystem;
	logic [TS_W-1:0]  now;

	modport source (output valid, output op, output subsystem, output now, input ready);
	modport sink   (input valid, input op, input subsystem, input now, output ready);
endinterface

// ----- rtl/core/sota_res_if.sv -----
`timescale 1ns / 1ps

interface sota_res_if;
	import sota_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [SUB_W-1:0]  unit;
	logic [TS_W-1:0]   accumulated;
	logic [TS_W-1:0]   record_time;
	logic              last;

	modport source (output valid, output kind, output unit, output accumulated,
		output record_time, output last, input ready);
	modport sink   (input valid, input kind, input unit, input accumulated,
		input record_time, input last, output ready);
endinterface

// ----- rtl/core/sota_datapath.sv -----
`timescale 1ns / 1ps

module sota_datapath #(
	parameter int NUM_UNITS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_fire,
	input  logic [sota_pkg::OP_W-1:0]     in_op,
	input  logic [sota_pkg::SUB_W-1:0]    in_subsystem,
	input  logic [sota_pkg::TS_W-1:0]     in_now,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  sota_pkg::sota_ctl_t           ctl,
	output sota_pkg::sota_stat_t          stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sota_pkg::KIND_W-1:0]   out_kind,
	output logic [sota_pkg::SUB_W-1:0]    out_unit,
	output logic [sota_pkg::TS_W-1:0]     out_accumulated,
	output logic [sota_pkg::TS_W-1:0]     out_record_time,
	output logic                          out_last
);
	import sota_pkg::*;

	localparam int AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam logic [SUB_W:0]  UNIT_LIMIT = (SUB_W+1)'(NUM_UNITS);
	localparam logic [AW-1:0]   IDX_LAST   = AW'(NUM_UNITS - 1);

	// item registers
	logic [OP_W-1:0]    op_q;
	logic [SUB_W-1:0]   sub_q;
	logic [TS_W-1:0]    now_q;
	logic [KIND_W-1:0]  kind_q;
	logic               en_q;

	// per-unit flags
	logic [NUM_UNITS-1:0] running_q;
	logic [NUM_UNITS-1:0] pending_q;
	logic [NUM_UNITS-1:0] tval_q;

	// walk counter and memory address
	logic [AW-1:0] idx_q;
	logic [AW-1:0] addr;

	// stamp and total memories
	logic [TS_W-1:0] start_mem [NUM_UNITS];
	logic [TS_W-1:0] total_mem [NUM_UNITS];
	logic            stamp_we;

	// read / arithmetic pipeline
	logic [TS_W-1:0] rd_start_s1;
	logic [TS_W-1:0] rd_total_s1;
	logic            tv_s1;
	logic            run_s1;
	logic [TS_W-1:0] diff_s2;
	logic [TS_W-1:0] tot_s2;
	logic [TS_W-1:0] sum_c;
	logic [TS_W-1:0] sum_q;

	// report held back until we know whether it is the final one
	logic             held_v_q;
	logic [SUB_W-1:0] held_unit_q;
	logic [TS_W-1:0]  held_sum_q;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [SUB_W-1:0]  out_unit_q;
	logic [TS_W-1:0]   out_acc_q;
	logic [TS_W-1:0]   out_rec_q;
	logic              out_last_q;

	assign addr     = ctl.use_idx ? idx_q : sub_q[AW-1:0];
	assign stamp_we = ctl.stamp_wr | (ctl.flush_upd & running_q[addr]);
	assign sum_c    = tot_s2 + diff_s2;

	// capture the accepted item and the result kind
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= in_op;
			sub_q <= in_subsystem;
			now_q <= in_now;
		end
		if (ctl.kind_ld) begin
			kind_q <= ctl.kind;
		end
		if (ctl.sum_ld) begin
			sum_q <= sum_c;
		end
	end

	// enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (cfg_we) begin
			en_q <= cfg_wdata;
		end
	end

	// unit flags; a cleared tval bit makes the stored total read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			pending_q <= '0;
			tval_q    <= '0;
		end else begin
			if (ctl.stamp_wr) begin
				running_q[addr] <= 1'b1;
				pending_q[addr] <= 1'b1;
			end
			if (ctl.stop_upd) begin
				running_q[addr] <= 1'b0;
				tval_q[addr]    <= 1'b1;
			end
			if (ctl.flush_upd) begin
				tval_q[addr] <= 1'b0;
				if (!running_q[addr]) begin
					pending_q[addr] <= 1'b0;
				end
			end
		end
	end

	// walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.idx_clr) begin
			idx_q <= '0;
		end else if (ctl.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// start stamp memory
	always_ff @(posedge clk) begin
		if (stamp_we) begin
			start_mem[addr] <= now_q;
		end
		rd_start_s1 <= start_mem[addr];
	end

	// total memory
	always_ff @(posedge clk) begin
		if (ctl.stop_upd) begin
			total_mem[addr] <= sum_c;
		end
		rd_total_s1 <= total_mem[addr];
	end

	// flags alongside the read data, then elapsed time and masked total
	always_ff @(posedge clk) begin
		tv_s1   <= tval_q[addr];
		run_s1  <= running_q[addr];
		diff_s2 <= run_s1 ? (now_q - rd_start_s1) : '0;
		tot_s2  <= tv_s1 ? rd_total_s1 : '0;
	end

	// held report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
		end else if (ctl.held_clr) begin
			held_v_q <= 1'b0;
		end else if (ctl.held_take) begin
			held_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.held_take) begin
			held_unit_q <= SUB_W'(idx_q);
			held_sum_q  <= sum_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (ctl.out_ld) begin
			unique case (ctl.out_sel)
				SEL_HELD: begin
					out_kind_q <= KIND_REPORT;
					out_unit_q <= held_unit_q;
					out_acc_q  <= held_sum_q;
					out_rec_q  <= now_q;
					out_last_q <= ctl.out_last;
				end
				SEL_EMPTY: begin
					out_kind_q <= KIND_EMPTY;
					out_unit_q <= '0;
					out_acc_q  <= '0;
					out_rec_q  <= now_q;
					out_last_q <= 1'b1;
				end
				default: begin
					out_kind_q <= kind_q;
					out_unit_q <= sub_q;
					out_acc_q  <= '0;
					out_rec_q  <= '0;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign out_kind        = out_kind_q;
	assign out_unit        = out_unit_q;
	assign out_accumulated = out_acc_q;
	assign out_record_time = out_rec_q;
	assign out_last        = out_last_q;

	// status back to the controller
	always_comb begin
		stat.op       = op_q;
		stat.en       = en_q;
		stat.in_range = {1'b0, sub_q} < UNIT_LIMIT;
		stat.run      = running_q[addr];
		stat.pend     = pending_q[idx_q];
		stat.idx_last = (idx_q == IDX_LAST);
		stat.sum_zero = (sum_q == '0);
		stat.held_v   = held_v_q;
		stat.out_free = !out_valid_q || out_ready;
	end

endmodule

// ----- rtl/core/sota_ctrl.sv -----
`timescale 1ns / 1ps

module sota_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  sota_pkg::sota_stat_t stat,
	output sota_pkg::sota_ctl_t  ctl
);
	import sota_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_STOP_DIFF,
		S_STOP_SUM,
		S_RESP,
		S_SCAN,
		S_FL_DIFF,
		S_FL_SUM,
		S_FL_EMIT,
		S_FL_END
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_nxt     = state_q;
		advance       = 1'b0;
		ctl           = '0;
		ctl.kind      = KIND_OK;
		ctl.out_sel   = SEL_SINGLE;

		unique case (state_q)
			// ready is high here, so a valid item is taken this cycle
			S_IDLE: begin
				ctl.ready = 1'b1;
				if (in_valid) begin
					state_nxt = S_DECODE;
				end
			end

			// classify the item; a stop's memory read is issued here
			S_DECODE: begin
				unique case (stat.op)
					OP_START, OP_STOP: begin
						ctl.kind_ld = 1'b1;
						state_nxt   = S_RESP;
						if (!stat.en || !stat.in_range) begin
							ctl.kind = KIND_DISABLED;
						end else if (stat.op == OP_START) begin
							if (stat.run) begin
								ctl.kind = KIND_REPEAT;
							end else begin
								ctl.stamp_wr = 1'b1;
							end
						end else if (!stat.run) begin
							ctl.kind = KIND_IDLE_STOP;
						end else begin
							state_nxt = S_STOP_DIFF;
						end
					end
					OP_FLUSH: begin
						ctl.idx_clr  = 1'b1;
						ctl.held_clr = 1'b1;
						state_nxt    = S_SCAN;
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end

			S_STOP_DIFF: begin
				state_nxt = S_STOP_SUM;
			end

			S_STOP_SUM: begin
				ctl.stop_upd = 1'b1;
				state_nxt    = S_RESP;
			end

			S_RESP: begin
				if (stat.out_free) begin
					ctl.out_ld = 1'b1;
					state_nxt  = S_IDLE;
				end
			end

			// skip units with nothing pending
			S_SCAN: begin
				ctl.use_idx = 1'b1;
				if (stat.pend) begin
					state_nxt = S_FL_DIFF;
				end else if (stat.idx_last) begin
					state_nxt = S_FL_END;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end

			S_FL_DIFF: begin
				ctl.use_idx = 1'b1;
				state_nxt   = S_FL_SUM;
			end

			S_FL_SUM: begin
				ctl.use_idx   = 1'b1;
				ctl.flush_upd = 1'b1;
				ctl.sum_ld    = 1'b1;
				state_nxt     = S_FL_EMIT;
			end

			// a new report pushes the held one out, not as final
			S_FL_EMIT: begin
				ctl.use_idx = 1'b1;
				if (stat.sum_zero) begin
					advance = 1'b1;
				end else if (!stat.held_v) begin
					ctl.held_take = 1'b1;
					advance       = 1'b1;
				end else if (stat.out_free) begin
					ctl.out_ld    = 1'b1;
					ctl.out_sel   = SEL_HELD;
					ctl.held_take = 1'b1;
					advance       = 1'b1;
				end
				if (advance) begin
					if (stat.idx_last) begin
						state_nxt = S_FL_END;
					end else begin
						ctl.idx_inc = 1'b1;
						state_nxt   = S_SCAN;
					end
				end
			end

			// final report, or the empty answer
			S_FL_END: begin
				if (stat.out_free) begin
					ctl.out_ld   = 1'b1;
					ctl.out_sel  = stat.held_v ? SEL_HELD : SEL_EMPTY;
					ctl.out_last = 1'b1;
					state_nxt    = S_IDLE;
				end
			end

			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/subsystem_on_time_accumulator_core.sv -----
`timescale 1ns / 1ps
`include "subsystem_on_time_accumulator_core_defines.svh"

// Per-subsystem on-time accumulator. Items on cmd start or stop a unit or
// flush all units; results come out on res, one per start/stop and one or
// more per flush (the final one of an item has last set). Start/stop are
// ignored and answered "disabled" until cfg_wdata=1 is written with cfg_we.
// Timing is set by a single-port stamp/total memory walked by a controller.
// A flush visits each unit once, and a pending one needs a read, a subtract,
// an add and a write. A stalled res holds up any item that has a result to
// give; one item is processed at a time and cmd.ready is high only between
// items.
module subsystem_on_time_accumulator_core #(
	parameter int NUM_UNITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	sota_cmd_if.sink    cmd,
	sota_res_if.source  res,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import sota_pkg::*;

	sota_ctl_t  ctl;
	sota_stat_t stat;
	logic       in_fire;

	assign in_fire   = cmd.valid & cmd.ready;
	assign cmd.ready = ctl.ready;

	sota_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.stat     (stat),
		.ctl      (ctl)
	);

	sota_datapath #(
		.NUM_UNITS (NUM_UNITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_fire         (in_fire),
		.in_op           (cmd.op),
		.in_subsystem    (cmd.subsystem),
		.in_now          (cmd.now),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.ctl             (ctl),
		.stat            (stat),
		.out_valid       (res.valid),
		.out_ready       (res.ready),
		.out_kind        (res.kind),
		.out_unit        (res.unit),
		.out_accumulated (res.accumulated),
		.out_record_time (res.record_time),
		.out_last        (res.last)
	);

	// checks
	`SOTA_ASSERT_SAME(a_report_nonzero, res.valid && res.kind == KIND_REPORT,
		res.accumulated != '0, "report with zero on-time")
	`SOTA_ASSERT_SAME(a_empty_shape, res.valid && res.kind == KIND_EMPTY,
		res.last && res.unit == '0 && res.accumulated == '0, "malformed empty flush result")
	`SOTA_ASSERT_SAME(a_single_shape,
		res.valid && res.kind != KIND_REPORT && res.kind != KIND_EMPTY,
		res.last && res.record_time == '0 && res.accumulated == '0,
		"malformed start/stop result")
	`SOTA_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready,
		"item accepted while previous one in progress")

endmodule

// ----- bench/tb_subsystem_on_time_accumulator_core.sv -----
`timescale 1ns / 1ps

module tb_subsystem_on_time_accumulator_core;
	import sota_pkg::*;

	localparam int NUM_UNITS     = 64;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int CHUNK_ITEMS   = 18;

	// op code the block decodes to nothing
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SUB_W-1:0] subsystem;
		logic [TS_W-1:0]  now;
	} cmd_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SUB_W-1:0]  unit;
		logic [TS_W-1:0]   accumulated;
		logic [TS_W-1:0]   record_time;
		logic              last;
	} res_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	sota_cmd_if cmd ();
	sota_res_if res ();

	subsystem_on_time_accumulator_core #(
		.NUM_UNITS(NUM_UNITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the per-unit bookkeeping
	logic            track_enable;
	logic [TS_W-1:0] unit_stamp   [NUM_UNITS];
	logic            unit_running [NUM_UNITS];
	logic [TS_W-1:0] unit_total   [NUM_UNITS];
	logic            unit_pending [NUM_UNITS];

	cmd_item_t pending_items[$];
	res_item_t due_results[$];

	cmd_item_t next_item;
	res_item_t got_item;
	res_item_t want_item;
	logic [TS_W-1:0] now_tick;

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int hold_requests;
	int hold_served;
	int hold_left;
	int cycle_count;

	// Works out the results one accepted item causes and updates the shadow.
	function automatic void account_item(input cmd_item_t it);
		res_item_t r;
		logic [TS_W-1:0] sum;
		int first_idx;
		int idx;
		r = '0;
		case (it.op)
			OP_START, OP_STOP: begin
				r.unit = it.subsystem;
				r.last = 1'b1;
				// disabled, or a unit index beyond the configured count
				if (!track_enable || int'(it.subsystem) >= NUM_UNITS) begin
					r.kind = KIND_DISABLED;
				end else if (it.op == OP_START) begin
					if (unit_running[it.subsystem]) begin
						r.kind = KIND_REPEAT;
					end else begin
						unit_stamp[it.subsystem]   = it.now;
						unit_running[it.subsystem] = 1'b1;
						unit_pending[it.subsystem] = 1'b1;
						r.kind = KIND_OK;
					end
				end else begin
					if (!unit_running[it.subsystem]) begin
						r.kind = KIND_IDLE_STOP;
					end else begin
						unit_total[it.subsystem] += it.now - unit_stamp[it.subsystem];
						unit_running[it.subsystem] = 1'b0;
						r.kind = KIND_OK;
					end
				end
				due_results.push_back(r);
			end
			OP_FLUSH: begin
				first_idx = due_results.size();
				for (int i = 0; i < NUM_UNITS; i++) begin
					if (unit_pending[i]) begin
						sum = unit_total[i];
						if (unit_running[i]) begin
							sum += it.now - unit_stamp[i];
							unit_stamp[i] = it.now;
						end else begin
							unit_pending[i] = 1'b0;
						end
						unit_total[i] = '0;
						if (sum != '0) begin
							r.kind        = KIND_REPORT;
							r.unit        = i[SUB_W-1:0];
							r.accumulated = sum;
							r.record_time = it.now;
							r.last        = 1'b0;
							due_results.push_back(r);
						end
					end
				end
				if (due_results.size() == first_idx) begin
					r             = '0;
					r.kind        = KIND_EMPTY;
					r.record_time = it.now;
					r.last        = 1'b1;
					due_results.push_back(r);
				end else begin
					idx = due_results.size() - 1;
					r = due_results[idx];
					r.last = 1'b1;
					due_results[idx] = r;
				end
			end
			default: begin
				// unknown op: no result, no change
			end
		endcase
	endfunction

	task automatic check_field(input string what, input logic [TS_W-1:0] want,
			input logic [TS_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			fail_count++;
		end
	endtask

	task automatic send_item(input logic [OP_W-1:0] op, input logic [SUB_W-1:0] sub,
			input logic [TS_W-1:0] stamp);
		cmd_item_t it;
		it.op        = op;
		it.subsystem = sub;
		it.now       = stamp;
		pending_items.push_back(it);
	endtask

	// Returns at a falling edge once nothing is queued, offered or owed.
	task automatic drain_results();
		@(negedge clk);
		while (pending_items.size() != 0 || cmd.valid || due_results.size() != 0)
			@(negedge clk);
	endtask

	// Enable write, only with the block idle; an unknown op may still be in flight.
	task automatic write_enable(input logic value);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		track_enable = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Mostly start/stop on a small window of units, some flushes, a bit of noise.
	task automatic queue_random(input int count, input int span);
		int r;
		int base;
		logic [OP_W-1:0] op;
		logic [SUB_W-1:0] sub;
		base = $urandom_range(NUM_UNITS - 1);
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 3)
				op = OP_UNUSED;
			else if (r < 13)
				op = OP_FLUSH;
			else if (r < 57)
				op = OP_START;
			else
				op = OP_STOP;
			sub = SUB_W'(base + $urandom_range(span - 1));
			if ($urandom_range(19) == 0)
				now_tick = {$urandom, $urandom};
			else
				now_tick += $urandom_range(1000, 1);
			send_item(op, sub, now_tick);
		end
	endtask

	// Start every unit, then flush: the longest burst of reports.
	task automatic queue_flood();
		for (int i = 0; i < NUM_UNITS; i++) begin
			now_tick += $urandom_range(50, 1);
			send_item(OP_START, SUB_W'(i), now_tick);
		end
		now_tick += $urandom_range(5000, 100);
		send_item(OP_FLUSH, SUB_W'($urandom_range(NUM_UNITS - 1)), now_tick);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("** subsystem_on_time_accumulator_core: FAILED **");
			$finish;
		end
	end

	// driver: one item offered at a time, held until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				account_item('{cmd.op, cmd.subsystem, cmd.now});
			end
			if (!cmd.valid || cmd.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_items.pop_front();
					cmd.valid     <= 1'b1;
					cmd.op        <= next_item.op;
					cmd.subsystem <= next_item.subsystem;
					cmd.now       <= next_item.now;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls plus long hold-offs on request
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res.ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_CYCLES;
			res.ready   <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: compare each taken result with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			got_item = '{res.kind, res.unit, res.accumulated, res.record_time, res.last};
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d unit %0d",
					$time, got_item.kind, got_item.unit);
				fail_count++;
			end else begin
				want_item = due_results.pop_front();
				check_field("kind", TS_W'(want_item.kind), TS_W'(got_item.kind));
				check_field("unit", TS_W'(want_item.unit), TS_W'(got_item.unit));
				check_field("accumulated", want_item.accumulated, got_item.accumulated);
				check_field("record_time", want_item.record_time, got_item.record_time);
				check_field("last", TS_W'(want_item.last), TS_W'(got_item.last));
			end
		end
	end

	// stimulus
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 1'b0;
		cmd.valid     = 1'b0;
		cmd.op        = OP_START;
		cmd.subsystem = '0;
		cmd.now       = '0;
		res.ready     = 1'b0;
		track_enable  = 1'b0;
		fail_count    = 0;
		hold_requests = 0;
		hold_served   = 0;
		hold_left     = 0;
		cycle_count   = 0;
		now_tick      = '0;
		send_idle_pct = 19;
		recv_idle_pct = 82;
		for (int i = 0; i < NUM_UNITS; i++) begin
			unit_stamp[i]   = '0;
			unit_running[i] = 1'b0;
			unit_total[i]   = '0;
			unit_pending[i] = 1'b0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// disabled after reset; flush still answers, unknown op is silent
		send_item(OP_START, 6'd0, '0);
		send_item(OP_STOP, 6'd63, '1);
		send_item(OP_FLUSH, 6'd5, 64'd5);
		send_item(OP_UNUSED, 6'd17, 64'd6);

		// enabled: repeat start, stop while idle, wrapping interval, reports
		write_enable(1'b1);
		send_item(OP_START, 6'd0, 64'd0);
		send_item(OP_START, 6'd0, 64'd7);
		send_item(OP_STOP, 6'd5, 64'd9);
		send_item(OP_START, 6'd63, 64'hFFFF_FFFF_FFFF_FFF0);
		send_item(OP_STOP, 6'd63, 64'd16);
		send_item(OP_STOP, 6'd0, 64'd100);
		send_item(OP_START, 6'd1, 64'd1000);
		send_item(OP_FLUSH, 6'd0, 64'd2000);
		// zero-length interval stays pending but reports nothing
		send_item(OP_START, 6'd2, 64'd50);
		send_item(OP_STOP, 6'd2, 64'd50);
		send_item(OP_FLUSH, 6'd0, 64'd2000);
		send_item(OP_FLUSH, 6'd63, '1);

		// disabled again: start/stop refused, flush still folds running time
		write_enable(1'b0);
		send_item(OP_START, 6'd3, 64'd4000);
		send_item(OP_STOP, 6'd1, 64'd4500);
		send_item(OP_FLUSH, 6'd0, 64'd5000);

		// random part, three stall profiles
		now_tick = {$urandom, $urandom};
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int chunk = 0; chunk < 3; chunk++) begin
				write_enable($urandom_range(3) != 0);
				queue_random(CHUNK_ITEMS, (chunk == 1) ? NUM_UNITS : 6);
				// long receiver hold while the sender keeps offering
				if (phase == 0 && chunk == 0)
					hold_requests++;
			end
			if (phase == 0) begin
				write_enable(1'b1);
				queue_flood();
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && due_results.size() == 0)
			$display("** subsystem_on_time_accumulator_core: PASSED **");
		else
			$display("** subsystem_on_time_accumulator_core: FAILED **");
		$finish;
	end

endmodule
